// ===== hw/rtl/sshfd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the stereo send/delay block.
package sshfd_pkg;

    localparam int DELAY_DEPTH = 65536;
    localparam int DLY_AW      = $clog2(DELAY_DEPTH);

    localparam logic [15:0] Q_ONE = 16'd32768;

    typedef enum logic [2:0] {
        CFG_HPF_ALPHA     = 3'd0,
        CFG_DELAY_ENABLE  = 3'd1,
        CFG_DELAY_LENGTH  = 3'd2,
        CFG_FEEDBACK_GAIN = 3'd3,
        CFG_WET_GAIN      = 3'd4
    } t_cfg_idx;

    // Coefficients and mode as seen by the channel datapath
    typedef struct packed {
        logic        en;
        logic [15:0] alpha;
        logic [15:0] fb;
        logic [15:0] wg;
    } t_coef;

    function automatic logic [15:0] clamp_coef(input logic [15:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    // round(c * x / 2^15), halves toward +inf
    function automatic logic signed [20:0] qmul(input logic [15:0] c,
                                                input logic signed [17:0] x);
        logic signed [35:0] cs;
        logic signed [35:0] xs;
        logic signed [35:0] p;
        cs = $signed({20'b0, c});
        xs = {{18{x[17]}}, x};
        p  = cs * xs + 36'sd16384;
        return p[35:15];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [20:0] v);
        logic signed [16:0] r;
        if (v > 21'sd65535) begin
            r = 17'sh0FFFF;
        end else if (v < -21'sd65536) begin
            r = 17'sh10000;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sshfd_chan.sv =====
// One channel of the datapath: one-pole high-pass, feedback write value and wet mix.
module sshfd_chan import sshfd_pkg::*; (
    input  t_coef              i_coef,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_last_in,
    input  logic signed [16:0] i_last_out,
    input  logic signed [15:0] i_dly,
    output logic signed [16:0] o_hpf,
    output logic signed [15:0] o_out,
    output logic signed [15:0] o_send,
    output logic signed [15:0] o_wr
);

    logic signed [17:0] diff;
    logic signed [15:0] send0;
    logic signed [20:0] send_ext;
    logic signed [20:0] fb_p;
    logic signed [20:0] wg_p;
    logic signed [17:0] dly_ext;

    always_comb begin
        diff     = {i_last_out[16], i_last_out} + {{2{i_x[15]}}, i_x}
                   - {{2{i_last_in[15]}}, i_last_in};
        o_hpf    = sat17(qmul(i_coef.alpha, diff));
        send0    = sat16({{4{o_hpf[16]}}, o_hpf});
        send_ext = {{5{send0[15]}}, send0};
        dly_ext  = {{2{i_dly[15]}}, i_dly};
        fb_p     = qmul(i_coef.fb, dly_ext);
        wg_p     = qmul(i_coef.wg, dly_ext);
        o_wr     = sat16(send_ext + fb_p);
        if (i_coef.en) begin
            o_out  = sat16({{5{i_x[15]}}, i_x} + wg_p);
            o_send = sat16(send_ext + wg_p);
        end else begin
            o_out  = i_x;
            o_send = send0;
        end
    end

endmodule

// ===== hw/rtl/stereo_send_highpass_feedback_delay.sv =====
// Stereo effects send: one-pole high-pass per channel plus a feedback delay line.
// One stereo frame is taken per clock while the output side does not stall. The delay
// memory is read at the input transfer edge, filter and mix run combinationally on
// the stage 1 registers, and the output register loads the result when stage 1
// advances, which waits while a held output is not taken. The rate is set by the
// registered memory read and the registered filter state, which is updated every
// frame. The delay memory is written when its item leaves stage 1, after its read;
// a read that lands on the entry being written in that cycle takes the new value by
// forwarding. Entries not yet written since reset read as zero: the write position
// together with a wrap flag tells written from unwritten, so no memory clearing pass
// follows reset. Configuration writes are taken every cycle and must only be issued
// while the block is idle.
module stereo_send_highpass_feedback_delay import sshfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] dry_left, [31:16] dry_right
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // out_left, out_right, send_left, send_right
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [15:0] r_hpf_alpha, r_delay_length, r_feedback_gain, r_wet_gain;
    logic        r_delay_enable;

    // stage 1
    logic               r_s1_valid;
    logic signed [15:0] r_s1_xl, r_s1_xr;
    logic [31:0]        r_rd_q;
    logic               r_rd_valid;
    logic               r_fwd_sel;
    logic [31:0]        r_fwd_data;

    // filter and delay state
    logic signed [15:0] r_last_in_l, r_last_in_r;
    logic signed [16:0] r_last_out_l, r_last_out_r;
    logic [DLY_AW-1:0]  r_wp;
    logic               r_wrapped;

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic [31:0] r_mem [DELAY_DEPTH];

    logic               s_xfer, s1_adv, mem_we;
    logic [DLY_AW-1:0]  wp_inc, n_wp, len_c, rd_addr;
    logic [DLY_AW:0]    rd_wrap;
    logic               n_wrapped, rd_ok, fwd_hit;
    logic signed [15:0] dly_l, dly_r;
    logic signed [16:0] hpf_l, hpf_r;
    logic signed [15:0] out_l, out_r, send_l, send_r, wr_l, wr_r;
    logic [31:0]        wr_data;
    t_coef              coef;

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign mem_we     = s1_adv && r_delay_enable;

    // alpha is used as written; only the delay gains are limited to unity
    assign coef.en    = r_delay_enable;
    assign coef.alpha = r_hpf_alpha;
    assign coef.fb    = clamp_coef(r_feedback_gain);
    assign coef.wg    = clamp_coef(r_wet_gain);

    // read address for the item being accepted, seen after this cycle's write
    always_comb begin
        if (r_wp == DLY_AW'(DELAY_DEPTH - 1)) begin
            wp_inc = '0;
        end else begin
            wp_inc = r_wp + 1'b1;
        end
        n_wp      = mem_we ? wp_inc : r_wp;
        n_wrapped = r_wrapped || (mem_we && (r_wp == DLY_AW'(DELAY_DEPTH - 1)));

        if (32'(r_delay_length) > 32'(DELAY_DEPTH - 1)) begin
            len_c = DLY_AW'(DELAY_DEPTH - 1);
        end else if (r_delay_length == 16'd0) begin
            len_c = DLY_AW'(1);
        end else begin
            len_c = DLY_AW'(r_delay_length);
        end

        rd_wrap = {1'b0, n_wp} + (DLY_AW + 1)'(DELAY_DEPTH) - {1'b0, len_c};
        if (n_wp >= len_c) begin
            rd_addr = n_wp - len_c;
        end else begin
            rd_addr = rd_wrap[DLY_AW-1:0];
        end
        rd_ok   = n_wrapped || (n_wp >= len_c);
        fwd_hit = mem_we && (rd_addr == r_wp);
    end

    always_comb begin
        if (r_fwd_sel) begin
            dly_l = r_fwd_data[15:0];
            dly_r = r_fwd_data[31:16];
        end else if (r_rd_valid) begin
            dly_l = r_rd_q[15:0];
            dly_r = r_rd_q[31:16];
        end else begin
            dly_l = '0;
            dly_r = '0;
        end
    end

    sshfd_chan u_chan_l (
        .i_coef     (coef),
        .i_x        (r_s1_xl),
        .i_last_in  (r_last_in_l),
        .i_last_out (r_last_out_l),
        .i_dly      (dly_l),
        .o_hpf      (hpf_l),
        .o_out      (out_l),
        .o_send     (send_l),
        .o_wr       (wr_l)
    );

    sshfd_chan u_chan_r (
        .i_coef     (coef),
        .i_x        (r_s1_xr),
        .i_last_in  (r_last_in_r),
        .i_last_out (r_last_out_r),
        .i_dly      (dly_r),
        .o_hpf      (hpf_r),
        .o_out      (out_r),
        .o_send     (send_r),
        .o_wr       (wr_r)
    );

    assign wr_data = {wr_r, wr_l};

    // delay memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= wr_data;
        end
        if (s_xfer) begin
            r_rd_q <= r_mem[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpf_alpha     <= 16'd31520;
            r_delay_enable  <= 1'b0;
            r_delay_length  <= 16'd12000;
            r_feedback_gain <= 16'd0;
            r_wet_gain      <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HPF_ALPHA:     r_hpf_alpha     <= i_cfg_data;
                CFG_DELAY_ENABLE:  r_delay_enable  <= i_cfg_data[0];
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data;
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data;
                CFG_WET_GAIN:      r_wet_gain      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_xl    <= i_s_tdata[15:0];
            r_s1_xr    <= i_s_tdata[31:16];
            r_rd_valid <= rd_ok;
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_sel <= 1'b0;
        end else if (s_xfer) begin
            r_fwd_sel <= fwd_hit;
        end else if (s1_adv) begin
            r_fwd_sel <= 1'b0;
        end
    end

    // filter state and write position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_in_l  <= '0;
            r_last_in_r  <= '0;
            r_last_out_l <= '0;
            r_last_out_r <= '0;
            r_wp         <= '0;
            r_wrapped    <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_last_in_l  <= r_s1_xl;
                r_last_in_r  <= r_s1_xr;
                r_last_out_l <= hpf_l;
                r_last_out_r <= hpf_r;
            end
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {send_r, send_l, out_r, out_l};
        end
    end

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wp) < DELAY_DEPTH)
        else $error("write position out of range");

    a_fwd_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_sel |-> r_s1_valid)
        else $error("forward select without item in stage 1");

    a_wp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mem_we |=> $stable(r_wp))
        else $error("write position moved without a delay write");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("stage 1 advanced but no output held");

endmodule
